FILE: rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared types of the quadratic root solver
// Holds the root classification codes used by the datapath and the result
// interface.
// ----------------------------------------------------------------------------
package qrs_pkg;

	// Classification of one equation.
	typedef enum logic [2:0] {
		KIND_TWO_REAL = 3'd0,
		KIND_DOUBLE   = 3'd1,
		KIND_COMPLEX  = 3'd2,
		KIND_LINEAR   = 3'd3,
		KIND_NONE     = 3'd4,
		KIND_EVERY    = 3'd5
	} kind_t;

endpackage

FILE: rtl/qrs_if.sv
// ----------------------------------------------------------------------------
// qrs_if: request and result channels of the quadratic root solver
// Valid/ready channels; a request moves at a clock edge with valid and ready
// both high.
// ----------------------------------------------------------------------------
interface qrs_in_if #(parameter int WORD_BITS = 32) ();
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] coef_a;
	logic signed [WORD_BITS-1:0] coef_b;
	logic signed [WORD_BITS-1:0] coef_c;

	modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
	modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_out_if import qrs_pkg::*; #(parameter int WORD_BITS = 32) ();
	logic                        valid;
	logic                        ready;
	kind_t                       root_kind;
	logic signed [WORD_BITS-1:0] first_value;
	logic signed [WORD_BITS-1:0] second_value;
	logic                        saturated;

	modport source (output valid, output root_kind, output first_value,
		output second_value, output saturated, input ready);
	modport sink (input valid, input root_kind, input first_value,
		input second_value, input saturated, output ready);
endinterface

FILE: rtl/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one digit of the restoring square root chain
// Brings two radicand bits into the partial remainder, settles one root bit
// and hands the request to the next cell.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell import qrs_pkg::*; #(
	parameter int SW     = 33,
	parameter int BIT    = 0,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              v_in,
	output logic              rdy_out,
	input  logic [2*SW-1:0]   x_in,
	input  logic [SW-1:0]     q_in,
	input  logic [SW+2:0]     r_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              v_out,
	input  logic              rdy_in,
	output logic [2*SW-1:0]   x_out,
	output logic [SW-1:0]     q_out,
	output logic [SW+2:0]     r_out,
	output logic [SIDE_W-1:0] side_out
);
	localparam int RW = SW + 3;

	logic [RW-1:0] r_sh;
	logic [RW-1:0] trial;
	logic [RW-1:0] r_nxt;
	logic [SW-1:0] q_nxt;

	// Trial subtraction of 4q+1 from the shifted remainder.
	always_comb begin
		r_sh  = {r_in[RW-3:0], x_in[2*BIT+1 -: 2]};
		trial = RW'({q_in, 2'b01});
		if (r_sh >= trial) begin
			r_nxt = r_sh - trial;
			q_nxt = {q_in[SW-2:0], 1'b1};
		end else begin
			r_nxt = r_sh;
			q_nxt = {q_in[SW-2:0], 1'b0};
		end
	end

	assign rdy_out = !v_out || rdy_in;

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (rdy_out) begin
			v_out <= v_in;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (rdy_out) begin
			x_out    <= x_in;
			q_out    <= q_nxt;
			r_out    <= r_nxt;
			side_out <= side_in;
		end
	end
endmodule

FILE: rtl/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell: one quotient bit of the restoring divider chain
// Two numerators share one divisor; each cell settles one bit of both
// quotients and hands the request on.
// ----------------------------------------------------------------------------
module qrs_div_cell import qrs_pkg::*; #(
	parameter int NW     = 50,
	parameter int DVW    = 33,
	parameter int BIT    = 0,
	parameter int SIDE_W = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              v_in,
	output logic              rdy_out,
	input  logic [NW-1:0]     n1_in,
	input  logic [NW-1:0]     n2_in,
	input  logic [NW-1:0]     q1_in,
	input  logic [NW-1:0]     q2_in,
	input  logic [DVW-1:0]    r1_in,
	input  logic [DVW-1:0]    r2_in,
	input  logic [DVW-1:0]    d_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              v_out,
	input  logic              rdy_in,
	output logic [NW-1:0]     n1_out,
	output logic [NW-1:0]     n2_out,
	output logic [NW-1:0]     q1_out,
	output logic [NW-1:0]     q2_out,
	output logic [DVW-1:0]    r1_out,
	output logic [DVW-1:0]    r2_out,
	output logic [DVW-1:0]    d_out,
	output logic [SIDE_W-1:0] side_out
);
	logic [DVW:0]   s1;
	logic [DVW:0]   s2;
	logic [DVW:0]   dx;
	logic [DVW:0]   t1;
	logic [DVW:0]   t2;
	logic [DVW-1:0] r1_nxt;
	logic [DVW-1:0] r2_nxt;
	logic [NW-1:0]  q1_nxt;
	logic [NW-1:0]  q2_nxt;

	// Compare and subtract for both lanes.
	always_comb begin
		s1     = {r1_in, n1_in[BIT]};
		s2     = {r2_in, n2_in[BIT]};
		dx     = {1'b0, d_in};
		t1     = s1 - dx;
		t2     = s2 - dx;
		q1_nxt = q1_in;
		q2_nxt = q2_in;
		if (s1 >= dx) begin
			r1_nxt      = t1[DVW-1:0];
			q1_nxt[BIT] = 1'b1;
		end else begin
			r1_nxt = s1[DVW-1:0];
		end
		if (s2 >= dx) begin
			r2_nxt      = t2[DVW-1:0];
			q2_nxt[BIT] = 1'b1;
		end else begin
			r2_nxt = s2[DVW-1:0];
		end
	end

	assign rdy_out = !v_out || rdy_in;

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (rdy_out) begin
			v_out <= v_in;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (rdy_out) begin
			n1_out   <= n1_in;
			n2_out   <= n2_in;
			q1_out   <= q1_nxt;
			q2_out   <= q2_nxt;
			r1_out   <= r1_nxt;
			r2_out   <= r2_nxt;
			d_out    <= d_in;
			side_out <= side_in;
		end
	end
endmodule

FILE: rtl/quadratic_root_solver_top.sv
// Path from request to result: stages 1 to 3, the square root cells, stage 4, the divider
// cells and the output register (Q16.16 by default). Throughput: one request per cycle
// while results are taken; every cell holds its own request and passes it on when ready.
// A stalled result stalls only the stages behind it that are full.
// Reset clears all valid bits; the pipeline is then empty and ready.
// ----------------------------------------------------------------------------
// quadratic_root_solver_top: fixed-point roots of a*x^2 + b*x + c = 0
// Splits the coefficients into sign and magnitude, forms the exact
// discriminant, takes its square root in a chain of digit cells and divides
// by 2a (or b) in a chain of quotient-bit cells, then saturates the results.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top import qrs_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input logic      clk,
	input logic      arst_n,
	qrs_in_if.sink   coef,
	qrs_out_if.source roots
);
	localparam int W      = WORD_BITS;
	localparam int DW     = 2 * W + 1;
	localparam int SW     = W + 1;
	localparam int RW     = SW + 3;
	localparam int NW     = W + 2 + FRAC_BITS;
	localparam int DVW    = W + 1;
	localparam int SIDE1  = 3 + DVW + 1 + 1 + W;
	localparam int SIDE2  = 5;

	// ---------------- Stage 1: sign and magnitude ----------------
	logic         v_s1, rdy_s1;
	logic [W-1:0] ma_s1, mb_s1, mc_s1;
	logic         na_s1, nb_s1, nc_s1;
	logic [W-1:0] ra, rb, rc;
	logic         rdy_s2;

	assign ra = coef.coef_a;
	assign rb = coef.coef_b;
	assign rc = coef.coef_c;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign coef.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= coef.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			na_s1 <= ra[W-1];
			nb_s1 <= rb[W-1];
			nc_s1 <= rc[W-1];
			ma_s1 <= ra[W-1] ? (~ra + W'(1)) : ra;
			mb_s1 <= rb[W-1] ? (~rb + W'(1)) : rb;
			mc_s1 <= rc[W-1] ? (~rc + W'(1)) : rc;
		end
	end

	// ---------------- Stage 2: products b*b and a*c ----------------
	logic           v_s2;
	logic [2*W-1:0] bb_s2, ac_s2;
	logic [W-1:0]   ma_s2, mb_s2, mc_s2;
	logic           na_s2, nb_s2, nc_s2;
	logic           rdy_s3;

	assign rdy_s2 = !v_s2 || rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			bb_s2 <= mb_s1 * mb_s1;
			ac_s2 <= ma_s1 * mc_s1;
			ma_s2 <= ma_s1;
			mb_s2 <= mb_s1;
			mc_s2 <= mc_s1;
			na_s2 <= na_s1;
			nb_s2 <= nb_s1;
			nc_s2 <= nc_s1;
		end
	end

	// ---------------- Stage 3: discriminant and classification ----------------
	logic              v_s3;
	logic [2*SW-1:0]   x_s3;
	logic [SIDE1-1:0]  side_s3;
	logic [DW-1:0]     bbx, ac4, dm;
	logic              dneg;
	kind_t             kind_c;
	logic [DVW-1:0]    den_c;
	logic              dsign_c, bneg_c;
	logic [W-1:0]      bmag_c;
	logic              sq_rdy0;

	assign rdy_s3 = !v_s3 || sq_rdy0;

	always_comb begin
		bbx  = DW'(bb_s2);
		// The product of two magnitudes is at most 2^(2W-2), so its top bit is zero.
		ac4  = {ac_s2[2*W-2:0], 2'b00};
		dneg = 1'b0;
		if (na_s2 != nc_s2) begin
			dm = bbx + ac4;
		end else if (bbx >= ac4) begin
			dm = bbx - ac4;
		end else begin
			dm   = ac4 - bbx;
			dneg = 1'b1;
		end
		if (ma_s2 != '0) begin
			den_c   = {ma_s2, 1'b0};
			dsign_c = na_s2;
			bneg_c  = !nb_s2;
			bmag_c  = mb_s2;
			if (dm == '0) begin
				kind_c = KIND_DOUBLE;
			end else if (dneg) begin
				kind_c = KIND_COMPLEX;
			end else begin
				kind_c = KIND_TWO_REAL;
			end
		end else begin
			den_c   = {1'b0, mb_s2};
			dsign_c = nb_s2;
			bneg_c  = !nc_s2;
			bmag_c  = mc_s2;
			if (mb_s2 != '0) begin
				kind_c = KIND_LINEAR;
			end else if (mc_s2 != '0) begin
				kind_c = KIND_NONE;
			end else begin
				kind_c = KIND_EVERY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			x_s3    <= (2*SW)'(dm);
			side_s3 <= {kind_c, den_c, dsign_c, bneg_c, bmag_c};
		end
	end

	// ---------------- Square root chain ----------------
	logic              sv   [SW+1];
	logic              srdy [SW+1];
	logic [2*SW-1:0]   sx   [SW+1];
	logic [SW-1:0]     sq   [SW+1];
	logic [RW-1:0]     sr   [SW+1];
	logic [SIDE1-1:0]  sside[SW+1];

	assign sv[0]    = v_s3;
	assign sx[0]    = x_s3;
	assign sq[0]    = '0;
	assign sr[0]    = '0;
	assign sside[0] = side_s3;
	assign sq_rdy0  = srdy[0];

	for (genvar k = 0; k < SW; k++) begin : g_sqrt
		qrs_sqrt_cell #(.SW(SW), .BIT(SW - 1 - k), .SIDE_W(SIDE1)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.v_in     (sv[k]),
			.rdy_out  (srdy[k]),
			.x_in     (sx[k]),
			.q_in     (sq[k]),
			.r_in     (sr[k]),
			.side_in  (sside[k]),
			.v_out    (sv[k+1]),
			.rdy_in   (srdy[k+1]),
			.x_out    (sx[k+1]),
			.q_out    (sq[k+1]),
			.r_out    (sr[k+1]),
			.side_out (sside[k+1])
		);
	end

	// ---------------- Stage 4: numerators ----------------
	logic              v_s4, rdy_s4;
	logic [NW-1:0]     n1_s4, n2_s4;
	logic [DVW-1:0]    d_s4;
	logic [SIDE2-1:0]  side_s4;
	kind_t             kind4;
	logic [DVW-1:0]    den4;
	logic              dsign4, bneg4;
	logic [W-1:0]      bmag4;
	logic [NW-1:0]     bm, rm, dif;
	logic              n1neg, n2neg;
	logic [NW-1:0]     n1m, n2m;
	logic              dv_rdy0;

	assign kind4 = kind_t'(sside[SW][SIDE1-1 -: 3]);
	assign {den4, dsign4, bneg4, bmag4} = sside[SW][SIDE1-4:0];
	assign srdy[SW] = rdy_s4;
	assign rdy_s4   = !v_s4 || dv_rdy0;

	// Signed-magnitude numerators: -b -/+ sqrt (two real), -b (double), -b and sqrt (complex), -c (linear).
	always_comb begin
		bm    = NW'(bmag4) << FRAC_BITS;
		rm    = NW'(sq[SW]) << FRAC_BITS;
		dif   = (bm >= rm) ? (bm - rm) : (rm - bm);
		n1neg = bneg4;
		n1m   = bm;
		n2neg = 1'b0;
		n2m   = '0;
		unique case (kind4)
			KIND_TWO_REAL: begin
				if (bneg4) begin
					n1neg = 1'b1;
					n1m   = bm + rm;
					n2neg = (bm >= rm);
					n2m   = dif;
				end else begin
					n1neg = !(bm >= rm);
					n1m   = dif;
					n2neg = 1'b0;
					n2m   = bm + rm;
				end
			end
			KIND_DOUBLE: begin
				n2neg = bneg4;
				n2m   = bm;
			end
			KIND_COMPLEX: begin
				n2m = rm;
			end
			KIND_LINEAR: begin
				n2m = '0;
			end
			default: begin
				n1neg = 1'b0;
				n1m   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= sv[SW];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			n1_s4   <= n1m;
			n2_s4   <= n2m;
			d_s4    <= den4;
			side_s4 <= {kind4, n1neg ^ dsign4, n2neg ^ dsign4};
		end
	end

	// ---------------- Divider chain ----------------
	logic              dv   [NW+1];
	logic              drdy [NW+1];
	logic [NW-1:0]     dn1  [NW+1];
	logic [NW-1:0]     dn2  [NW+1];
	logic [NW-1:0]     dq1  [NW+1];
	logic [NW-1:0]     dq2  [NW+1];
	logic [DVW-1:0]    dr1  [NW+1];
	logic [DVW-1:0]    dr2  [NW+1];
	logic [DVW-1:0]    dd   [NW+1];
	logic [SIDE2-1:0]  dside[NW+1];

	assign dv[0]    = v_s4;
	assign dn1[0]   = n1_s4;
	assign dn2[0]   = n2_s4;
	assign dq1[0]   = '0;
	assign dq2[0]   = '0;
	assign dr1[0]   = '0;
	assign dr2[0]   = '0;
	assign dd[0]    = d_s4;
	assign dside[0] = side_s4;
	assign dv_rdy0  = drdy[0];

	for (genvar k = 0; k < NW; k++) begin : g_div
		qrs_div_cell #(.NW(NW), .DVW(DVW), .BIT(NW - 1 - k), .SIDE_W(SIDE2)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.v_in     (dv[k]),
			.rdy_out  (drdy[k]),
			.n1_in    (dn1[k]),
			.n2_in    (dn2[k]),
			.q1_in    (dq1[k]),
			.q2_in    (dq2[k]),
			.r1_in    (dr1[k]),
			.r2_in    (dr2[k]),
			.d_in     (dd[k]),
			.side_in  (dside[k]),
			.v_out    (dv[k+1]),
			.rdy_in   (drdy[k+1]),
			.n1_out   (dn1[k+1]),
			.n2_out   (dn2[k+1]),
			.q1_out   (dq1[k+1]),
			.q2_out   (dq2[k+1]),
			.r1_out   (dr1[k+1]),
			.r2_out   (dr2[k+1]),
			.d_out    (dd[k+1]),
			.side_out (dside[k+1])
		);
	end

	// ---------------- Output register with saturation ----------------
	logic         v_q, rdy_o;
	kind_t        kind_q;
	logic [W-1:0] first_q, second_q;
	logic         sat_q;
	kind_t        kind5;
	logic         neg1, neg2;
	logic [W:0]   e1, e2;
	logic [W-1:0] first_c, second_c;
	logic         sat_c;

	// Clip a signed-magnitude quotient to the word range; returns {clipped, word}.
	function automatic logic [W:0] emit(input logic neg, input logic [NW-1:0] mag);
		logic [NW-1:0] lim;
		logic [NW-1:0] m;
		logic [NW-1:0] t;
		logic          s;
		lim = neg ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - NW'(1));
		m   = mag;
		s   = 1'b0;
		if (mag > lim) begin
			m = lim;
			s = 1'b1;
		end
		t = neg ? (NW'(0) - m) : m;
		return {s, t[W-1:0]};
	endfunction

	assign kind5 = kind_t'(dside[NW][SIDE2-1 -: 3]);
	assign {neg1, neg2} = dside[NW][1:0];
	assign e1 = emit(neg1, dq1[NW]);
	assign e2 = emit(neg2, dq2[NW]);

	always_comb begin
		first_c  = e1[W-1:0];
		second_c = e2[W-1:0];
		sat_c    = e1[W] | e2[W];
		unique case (kind5)
			KIND_TWO_REAL, KIND_COMPLEX: begin
			end
			KIND_DOUBLE: begin
				second_c = e1[W-1:0];
				sat_c    = e1[W];
			end
			KIND_LINEAR: begin
				second_c = '0;
				sat_c    = e1[W];
			end
			default: begin
				first_c  = '0;
				second_c = '0;
				sat_c    = 1'b0;
			end
		endcase
	end

	assign rdy_o    = !v_q || roots.ready;
	assign drdy[NW] = rdy_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy_o) begin
			v_q <= dv[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o) begin
			kind_q   <= kind5;
			first_q  <= first_c;
			second_q <= second_c;
			sat_q    <= sat_c;
		end
	end

	assign roots.valid        = v_q;
	assign roots.root_kind    = kind_q;
	assign roots.first_value  = first_q;
	assign roots.second_value = second_q;
	assign roots.saturated    = sat_q;

`ifndef ASSERT_OFF
	// No root and every x carry zero values and no clipping.
	a_zero_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && (kind_q == KIND_NONE || kind_q == KIND_EVERY) |->
		first_q == '0 && second_q == '0 && !sat_q)
		else $error("empty root kinds must carry zero values");

	// A linear root leaves the second value at zero.
	a_linear: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && kind_q == KIND_LINEAR |-> second_q == '0)
		else $error("linear result with nonzero second value");

	// A double root repeats the same value.
	a_double: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && kind_q == KIND_DOUBLE |-> first_q == second_q)
		else $error("double root values differ");

	// Clipping leaves at least one value at a range limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && sat_q |->
		first_q == {1'b1, {(W-1){1'b0}}} || first_q == {1'b0, {(W-1){1'b1}}} ||
		second_q == {1'b1, {(W-1){1'b0}}} || second_q == {1'b0, {(W-1){1'b1}}})
		else $error("saturation flag without a limit value");
`endif
endmodule

FILE: dv/tb_quadratic_root_solver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_top: self-checking bench of the quadratic solver
// Sends directed and random coefficient requests with random idle bursts on
// both sides. A scoreboard predicts each result with wide integer arithmetic
// and compares it field by field, in order, with what the block returns.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver_top;
	import qrs_pkg::*;

	localparam int WB = 32;
	localparam int FB = 16;
	localparam int LATENCY = 2 * WB + FB + 8;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		kind_t        root_kind;
		logic [WB-1:0] first_value;
		logic [WB-1:0] second_value;
		logic          saturated;
	} roots_t;

	// Predicts and holds the expected roots of each accepted request.
	class root_scoreboard;
		roots_t pending[$];
		int     errors;

		// Clip a wide signed value to the word range.
		function logic [WB-1:0] clip(logic signed [199:0] v, inout logic sat);
			logic signed [199:0] hi_lim;
			logic signed [199:0] lo_lim;
			hi_lim = (200'sd1 <<< (WB - 1)) - 1;
			lo_lim = -(200'sd1 <<< (WB - 1));
			if (v > hi_lim) begin
				sat = 1'b1;
				return hi_lim[WB-1:0];
			end
			if (v < lo_lim) begin
				sat = 1'b1;
				return lo_lim[WB-1:0];
			end
			return v[WB-1:0];
		endfunction

		// Integer square root, floor, of a nonnegative value.
		function logic [99:0] floor_sqrt(logic [199:0] v);
			logic [99:0] r;
			logic [99:0] t;
			r = '0;
			for (int i = 99; i >= 0; i--) begin
				t = r | (100'd1 << i);
				if ({100'd0, t} * {100'd0, t} <= v)
					r = t;
			end
			return r;
		endfunction

		function void note_request(logic signed [WB-1:0] a, logic signed [WB-1:0] b,
				logic signed [WB-1:0] c);
			logic signed [199:0] wa, wb, wc, disc, root, den, num;
			roots_t r;
			logic sat;
			wa = a;
			wb = b;
			wc = c;
			sat = 1'b0;
			r.first_value = '0;
			r.second_value = '0;
			if (wa != 0) begin
				disc = wb * wb - 4 * wa * wc;
				root = $signed({100'd0, floor_sqrt(disc < 0 ? -disc : disc)}) <<< FB;
				den = 2 * wa;
				num = -(wb <<< FB);
				// Signed division in SystemVerilog truncates toward zero.
				if (disc == 0) begin
					r.root_kind = KIND_DOUBLE;
					r.first_value = clip(num / den, sat);
					r.second_value = r.first_value;
				end else if (disc > 0) begin
					r.root_kind = KIND_TWO_REAL;
					r.first_value = clip((num - root) / den, sat);
					r.second_value = clip((num + root) / den, sat);
				end else begin
					r.root_kind = KIND_COMPLEX;
					r.first_value = clip(num / den, sat);
					r.second_value = clip(root / den, sat);
				end
			end else if (wb != 0) begin
				r.root_kind = KIND_LINEAR;
				r.first_value = clip(-(wc <<< FB) / wb, sat);
			end else if (wc != 0) begin
				r.root_kind = KIND_NONE;
			end else begin
				r.root_kind = KIND_EVERY;
			end
			r.saturated = sat;
			pending.push_back(r);
		endfunction

		function void check_result(roots_t got);
			roots_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result kind=%0d", $realtime, got.root_kind);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.root_kind !== exp_r.root_kind) begin
				$display("%0t: root_kind expected %0d actual %0d", $realtime,
					exp_r.root_kind, got.root_kind);
				errors++;
			end
			if (got.first_value !== exp_r.first_value) begin
				$display("%0t: first_value expected %h actual %h", $realtime,
					exp_r.first_value, got.first_value);
				errors++;
			end
			if (got.second_value !== exp_r.second_value) begin
				$display("%0t: second_value expected %h actual %h", $realtime,
					exp_r.second_value, got.second_value);
				errors++;
			end
			if (got.saturated !== exp_r.saturated) begin
				$display("%0t: saturated expected %0b actual %0b", $realtime,
					exp_r.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	longint cycles = 0;
	bit quiet_phase;
	bit hold_results;
	root_scoreboard sb;

	qrs_in_if #(.WORD_BITS(WB)) coef ();
	qrs_out_if #(.WORD_BITS(WB)) roots ();

	quadratic_root_solver_top #(.WORD_BITS(WB), .FRAC_BITS(FB)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef.sink),
		.roots  (roots.source)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Cycle count and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Check every accepted result.
	always @(posedge clk) begin
		if (arst_n && roots.valid && roots.ready)
			sb.check_result({roots.root_kind, roots.first_value, roots.second_value,
				roots.saturated});
	end

	// Result side: random stall bursts, or one long hold when asked.
	initial begin
		int burst;
		bit held;
		held = 1'b0;
		roots.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_results && !held) begin
				held = 1'b1;
				roots.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 8);
				roots.ready <= 1'b0;
				repeat (burst - 1) @(posedge clk);
			end else begin
				roots.ready <= 1'b1;
			end
		end
	end

	// Offer one request and wait for it to be taken.
	task automatic send_request(logic [WB-1:0] a, logic [WB-1:0] b, logic [WB-1:0] c);
		int burst;
		if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			burst = $urandom_range(1, 8);
			coef.valid <= 1'b0;
			repeat (burst) @(posedge clk);
		end
		coef.valid <= 1'b1;
		coef.coef_a <= a;
		coef.coef_b <= b;
		coef.coef_c <= c;
		do
			@(posedge clk);
		while (!coef.ready);
		sb.note_request(a, b, c);
	endtask

	task automatic wait_drained();
		coef.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [WB-1:0] rand_coef();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return $urandom_range(0, 16) << FB;
			4: return -($urandom_range(0, 16) << FB);
			5: return $signed($urandom_range(0, 4095)) - 2048;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic [WB-1:0] a, b, c;
		int k;
		sb = new();
		quiet_phase = 1'b0;
		hold_results = 1'b0;
		coef.valid = 1'b0;
		coef.coef_a = '0;
		coef.coef_b = '0;
		coef.coef_c = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every root kind, field extremes, saturating cases.
		send_request(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
		send_request(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
		send_request(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
		send_request(32'h0000_0000, 32'h0002_0000, 32'h0004_0000);
		send_request(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
		send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_request(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);
		send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_request(32'h0000_0000, 32'h0000_0001, 32'h7fff_ffff);
		send_request(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000);
		send_request(32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff);
		send_request(32'h0000_0001, 32'h0000_0000, 32'h0000_0001);
		send_request(32'hffff_0000, 32'h0004_0000, 32'h0000_0000);
		send_request(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
		send_request(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

		// Sender pauses until every result has come.
		wait_drained();

		// Long hold on the result side while requests keep coming.
		hold_results = 1'b1;
		for (int i = 0; i < 1600; i++) begin
			if (i == 1300)
				quiet_phase = 1'b1;
			k = $urandom_range(0, 3);
			if (k == 0) begin
				// Build a perfect-square, double-root case from a chosen root.
				a = $urandom_range(1, 8) << FB;
				b = -(2 * ($signed(a) >>> FB) * ($signed($urandom_range(0, 20)) - 10)) << FB;
				c = (($signed(b) >>> FB) * ($signed(b) >>> FB) /
					(4 * ($signed(a) >>> FB))) << FB;
			end else begin
				a = rand_coef();
				b = rand_coef();
				c = rand_coef();
			end
			send_request(a, b, c);
		end
		wait_drained();
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
